>>> rtl/core/pafk_pkg.sv
// Shared types and constants for the planar arm forward kinematics block.
// No dependencies; every module of the block imports this package.
package pafk_pkg;

	// Segment length is unsigned Q8.8.
	localparam int LEN_W = 16;

	// CORDIC datapath: guard bits below the coordinate LSB, gain correction in Q30.
	localparam int GUARD = 14;
	localparam int KINV_W = 30;
	localparam logic [KINV_W-1:0] KINV_Q30 = 30'd652032874;
	localparam int PROD_W = LEN_W + KINV_W;
	localparam int KINV_SHIFT = 30 - GUARD;

	// Rotation vector and residual angle widths (angle scaled to 2^32 per turn).
	localparam int CW = 34;
	localparam int ZW = 34;
	localparam int DW = CW - GUARD;
	localparam int Z_SCALE_BITS = 32;

	// Arctangent table, 2^32 units per turn.
	localparam int ATAN_N = 24;
	localparam logic [31:0] ATAN_TURN32 [0:ATAN_N-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Queue between the trig pipeline and the point accumulator.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = 2;
	localparam int Q_CW = 3;

	typedef enum logic [1:0] {
		QUAD_I,
		QUAD_II,
		QUAD_III,
		QUAD_IV
	} pafk_quad_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pafk_qstat_t;

endpackage

>>> rtl/core/planar_arm_forward_kinematics_top.sv
// Planar arm forward kinematics, one segment per transaction, base segment first.
// Registered path: input, quadrant and gain, CORDIC stages, queue, output.
// Throughput: one transaction per cycle while the queue has room; the CORDIC is
// fully pipelined and only the input angle add and saturating point add feed back.
// Reset (arst_n low): running angle and last end point go to zero, all queues empty.
module planar_arm_forward_kinematics_top #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 24,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// Bits from LSB: joint_angle, segment_length, zero padding.
	input  logic [((ANGLE_BITS+pafk_pkg::LEN_W+7)/8)*8-1:0] s_axis_tdata,
	// Bits from LSB: is_base.
	input  logic [0:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// Bits from LSB: mount_x, mount_y, end_x, end_y, absolute_angle, zero padding.
	output logic [((4*COORD_BITS+ANGLE_BITS+7)/8)*8-1:0] m_axis_tdata
);
	import pafk_pkg::*;

	localparam int QW = 1 + ANGLE_BITS + 2 * DW;
	localparam int OUT_TW = ((4 * COORD_BITS + ANGLE_BITS + 7) / 8) * 8;

	pafk_qstat_t qstat;
	logic push;
	logic pop;
	logic [QW-1:0] push_data;
	logic [QW-1:0] pop_data;
	logic [COORD_BITS-1:0] mount_x;
	logic [COORD_BITS-1:0] mount_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;
	logic [ANGLE_BITS-1:0] absolute_angle;

	pafk_front #(
		.ANGLE_BITS(ANGLE_BITS),
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_base(s_axis_tuser[0]),
		.in_angle(s_axis_tdata[ANGLE_BITS-1:0]),
		.in_len(s_axis_tdata[ANGLE_BITS+LEN_W-1:ANGLE_BITS]),
		.qstat(qstat),
		.push(push),
		.push_data(push_data)
	);

	pafk_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.qstat(qstat)
	);

	pafk_back #(
		.ANGLE_BITS(ANGLE_BITS),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.pop(pop),
		.pop_data(pop_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.mount_x(mount_x),
		.mount_y(mount_y),
		.end_x(end_x),
		.end_y(end_y),
		.absolute_angle(absolute_angle)
	);

	assign m_axis_tdata = OUT_TW'({absolute_angle, end_y, end_x, mount_y, mount_x});

endmodule

>>> rtl/core/pafk_front.sv
// Front end: angle accumulation, quadrant reduction and a pipelined CORDIC rotation.
// Depends on pafk_pkg; pushes finished offsets into pafk_queue.
module pafk_front #(
	parameter int ANGLE_BITS = 16,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_base,
	input  logic [ANGLE_BITS-1:0] in_angle,
	input  logic [pafk_pkg::LEN_W-1:0] in_len,
	input  pafk_pkg::pafk_qstat_t qstat,
	output logic push,
	output logic [1+ANGLE_BITS+2*pafk_pkg::DW-1:0] push_data
);
	import pafk_pkg::*;

	localparam int N = TRIG_ITERATIONS;
	localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(1) << (ANGLE_BITS - 3);
	localparam logic signed [CW-1:0] ROUND_HALF = CW'(1) << (GUARD - 1);

	logic adv;
	logic take;
	logic [ANGLE_BITS-1:0] angle_q;
	logic [ANGLE_BITS-1:0] next_angle;

	logic v_s1;
	logic base_s1;
	logic [ANGLE_BITS-1:0] angle_s1;
	logic [LEN_W-1:0] len_s1;

	logic [ANGLE_BITS-1:0] oct_sum;
	logic [ANGLE_BITS-1:0] resid;
	logic [PROD_W-1:0] prod;

	logic v_s [0:N];
	logic b_s [0:N];
	logic [ANGLE_BITS-1:0] a_s [0:N];
	pafk_quad_t q_s [0:N];
	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [ZW-1:0] z_s [0:N];

	logic signed [CW-1:0] xr;
	logic signed [CW-1:0] yr;
	logic signed [DW-1:0] rx;
	logic signed [DW-1:0] ry;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;

	// The whole pipeline holds while the queue is full.
	assign adv = ~qstat.full;
	assign in_ready = adv;
	assign take = in_valid & adv;
	assign next_angle = in_base ? in_angle : angle_q + in_angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			v_s1 <= 1'b0;
			for (int i = 0; i <= N; i++) begin
				v_s[i] <= 1'b0;
			end
		end else begin
			if (take) begin
				angle_q <= next_angle;
			end
			if (adv) begin
				v_s1 <= take;
				v_s[0] <= v_s1;
				for (int i = 0; i < N; i++) begin
					v_s[i+1] <= v_s[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s1 <= in_base;
			angle_s1 <= next_angle;
			len_s1 <= in_len;
		end
	end

	// Quadrant from the top two bits of angle plus one eighth turn; the residual
	// lies within plus or minus one eighth turn.
	assign oct_sum = angle_s1 + EIGHTH;
	assign resid = angle_s1 - {oct_sum[ANGLE_BITS-1 -: 2], {(ANGLE_BITS-2){1'b0}}};
	assign prod = PROD_W'(len_s1) * PROD_W'(KINV_Q30);

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s[0] <= base_s1;
			a_s[0] <= angle_s1;
			q_s[0] <= pafk_quad_t'(oct_sum[ANGLE_BITS-1 -: 2]);
			x_s[0] <= $signed(CW'(prod[PROD_W-1:KINV_SHIFT]));
			y_s[0] <= '0;
			z_s[0] <= ZW'($signed(resid)) <<< (Z_SCALE_BITS - ANGLE_BITS);
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		localparam logic signed [ZW-1:0] AT_I = $signed(ZW'(ATAN_TURN32[i]));

		always_ff @(posedge clk) begin
			if (adv) begin
				b_s[i+1] <= b_s[i];
				a_s[i+1] <= a_s[i];
				q_s[i+1] <= q_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AT_I;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AT_I;
				end
			end
		end
	end

	// Round off the guard bits, then rotate back by whole quadrants.
	assign xr = x_s[N] + ROUND_HALF;
	assign yr = y_s[N] + ROUND_HALF;
	assign rx = xr[CW-1:GUARD];
	assign ry = yr[CW-1:GUARD];

	always_comb begin
		case (q_s[N])
			QUAD_I: begin
				dx = rx;
				dy = ry;
			end
			QUAD_II: begin
				dx = -ry;
				dy = rx;
			end
			QUAD_III: begin
				dx = -rx;
				dy = -ry;
			end
			default: begin
				dx = ry;
				dy = -rx;
			end
		endcase
	end

	assign push = adv & v_s[N];
	assign push_data = {b_s[N], a_s[N], dx, dy};

endmodule

>>> rtl/core/pafk_queue.sv
// Short FIFO that decouples the trig pipeline from the point accumulator.
// Depends on pafk_pkg for its depth and status type.
module pafk_queue #(
	parameter int W = 57
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [W-1:0] push_data,
	input  logic pop,
	output logic [W-1:0] pop_data,
	output pafk_pkg::pafk_qstat_t qstat
);
	import pafk_pkg::*;

	logic [W-1:0] mem [0:Q_DEPTH-1];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	assign qstat.full = (count_q == Q_CW'(Q_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/pafk_back.sv
// Back end: chains segment offsets onto the previous end point with saturation.
// Depends on pafk_pkg; pops from pafk_queue and drives the output register.
module pafk_back #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  pafk_pkg::pafk_qstat_t qstat,
	output logic pop,
	input  logic [1+ANGLE_BITS+2*pafk_pkg::DW-1:0] pop_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [COORD_BITS-1:0] mount_x,
	output logic [COORD_BITS-1:0] mount_y,
	output logic [COORD_BITS-1:0] end_x,
	output logic [COORD_BITS-1:0] end_y,
	output logic [ANGLE_BITS-1:0] absolute_angle
);
	import pafk_pkg::*;

	localparam int QW = 1 + ANGLE_BITS + 2 * DW;
	localparam int SW = ((COORD_BITS > DW) ? COORD_BITS : DW) + 1;

	logic base;
	logic [ANGLE_BITS-1:0] angle;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [COORD_BITS-1:0] last_x_q;
	logic signed [COORD_BITS-1:0] last_y_q;
	logic signed [COORD_BITS-1:0] mx;
	logic signed [COORD_BITS-1:0] my;
	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;
	logic signed [COORD_BITS-1:0] ex;
	logic signed [COORD_BITS-1:0] ey;
	logic valid_q;
	logic [COORD_BITS-1:0] mount_x_q;
	logic [COORD_BITS-1:0] mount_y_q;
	logic [COORD_BITS-1:0] end_x_q;
	logic [COORD_BITS-1:0] end_y_q;
	logic [ANGLE_BITS-1:0] angle_q;

	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SW-1:0] v);
		logic [SW-COORD_BITS:0] top;
		top = v[SW-1:COORD_BITS-1];
		if ((&top) || !(|top)) begin
			return v[COORD_BITS-1:0];
		end else if (v[SW-1]) begin
			return {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_BITS-1){1'b1}}};
		end
	endfunction

	assign base = pop_data[QW-1];
	assign angle = pop_data[QW-2 -: ANGLE_BITS];
	assign dx = pop_data[2*DW-1:DW];
	assign dy = pop_data[DW-1:0];

	// A base segment mounts at the origin; any other at the previous end point.
	assign mx = base ? '0 : last_x_q;
	assign my = base ? '0 : last_y_q;
	assign sum_x = SW'(mx) + SW'(dx);
	assign sum_y = SW'(my) + SW'(dy);
	assign ex = sat(sum_x);
	assign ey = sat(sum_y);

	assign pop = ~qstat.empty & (~valid_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				last_x_q <= ex;
				last_y_q <= ey;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mount_x_q <= mx;
			mount_y_q <= my;
			end_x_q <= ex;
			end_y_q <= ey;
			angle_q <= angle;
		end
	end

	assign out_valid = valid_q;
	assign mount_x = mount_x_q;
	assign mount_y = mount_y_q;
	assign end_x = end_x_q;
	assign end_y = end_y_q;
	assign absolute_angle = angle_q;

endmodule
